// ----- hdl/mtdf_pkg.sv -----
package mtdf_pkg;

    // Time inputs are taken in their low TIME_BITS bits (16..31).
    localparam int TIME_BITS = 31;

    localparam int ROUND_MS = 500;

    // Widths below are upper bounds for any TIME_BITS up to 31.
    localparam int X_W  = 32;  // ms + 500
    localparam int TS_W = 22;  // whole seconds
    localparam int MT_W = 16;  // whole minutes
    localparam int HR_W = 10;  // whole hours

    // x / 1000 = (x >> 3) / 125, by reciprocal multiply.
    localparam int K125   = (X_W - 3) + 7;
    localparam int M125_W = 30;
    localparam longint unsigned R125 = ((64'd1 << K125) + 64'd124) / 64'd125;
    localparam int P1_W   = (X_W - 3) + M125_W;

    // seconds / 60 = (s >> 2) / 15
    localparam int K15S   = (TS_W - 2) + 4;
    localparam int M15S_W = 21;
    localparam longint unsigned R15S = ((64'd1 << K15S) + 64'd14) / 64'd15;
    localparam int P2_W   = (TS_W - 2) + M15S_W;

    // minutes / 60 = (m >> 2) / 15
    localparam int K15M   = (MT_W - 2) + 4;
    localparam int M15M_W = 15;
    localparam longint unsigned R15M = ((64'd1 << K15M) + 64'd14) / 64'd15;
    localparam int P3_W   = (MT_W - 2) + M15M_W;

    // hours / 100 for hours below 1024: (h * 41) >> 12
    localparam int H100_W = HR_W + 6;

    localparam logic OP_REPORT   = 1'b0;
    localparam logic OP_FORCED   = 1'b1;
    localparam logic EV_DURATION = 1'b0;
    localparam logic EV_ELAPSED  = 1'b1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        HW_NONE,
        HW_ONE,
        HW_TWO
    } t_hour_w;

    typedef struct packed {
        logic [3:0] h1;
        logic [3:0] h0;
        logic [3:0] m1;
        logic [3:0] m0;
        logic [3:0] s1;
        logic [3:0] s0;
    } t_digits;

    typedef struct packed {
        logic    emit_dur;
        logic    emit_el;
        t_hour_w hour_w;
        logic    min_two;
        t_digits dur;
        t_digits el;
    } t_fmt_entry;

    // Two decimal digits of a value below 100: {tens, ones}.
    function automatic logic [7:0] split10(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  o;
        p = 15'(v) * 15'd205;
        t = p[14:11];
        o = v - 7'(t) * 7'd10;
        return {t, o[3:0]};
    endfunction

endpackage

// ----- hdl/mtdf_if.sv -----
interface mtdf_in_if import mtdf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [TIME_BITS-1:0] position_ms;
    logic [TIME_BITS-1:0] length_ms;

    modport source (output valid, output operation, output position_ms,
                    output length_ms, input ready);
    modport sink   (input valid, input operation, input position_ms,
                    input length_ms, output ready);
endinterface

interface mtdf_out_if import mtdf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       event_kind;
    logic [7:0] character;
    logic       string_end;
    logic       item_end;

    modport source (output valid, output event_kind, output character,
                    output string_end, output item_end, input ready);
    modport sink   (input valid, input event_kind, input character,
                    input string_end, input item_end, output ready);
endinterface

// ----- hdl/media_time_display_formatter.sv -----
// Media time formatter: each accepted position/length report passes a
// five-stage arithmetic front end (round to seconds, split into hours,
// minutes and seconds by reciprocal multiplies, decide which strings are
// due) and lands in a four-entry queue; the back end then sends the
// duration and/or elapsed string one ASCII character per beat, 0 to 16
// beats per report, with string_end on each string's last character and
// item_end on the report's last one. Reports that cause no string produce
// no beats. Input is taken every cycle while the queue has room, so
// throughput is set by the character serializer at one beat per cycle
// while the sink holds ready. From the input beat, a report passes
// stage registers A to E and the queue, then the registered output.
module media_time_display_formatter import mtdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtdf_in_if.sink    i_in,
    mtdf_out_if.source o_out
);

    t_fmt_entry push_data, head_data;
    logic       push, full, pop, head_valid;

    mtdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_entry (push_data),
        .o_push  (push),
        .i_full  (full)
    );

    mtdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_valid (head_valid)
    );

    mtdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head_data),
        .i_valid (head_valid),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- hdl/mtdf_front.sv -----
module mtdf_front import mtdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtdf_in_if.sink    i_in,
    output t_fmt_entry o_entry,
    output logic       o_push,
    input  logic       i_full
);

    // report state
    logic [TIME_BITS-1:0] r_stored_len;
    logic                 r_len_known;
    logic [TS_W-1:0]      r_last_sec;
    logic                 r_pos_known;

    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;

    // stage A: classified report
    logic                 r_a_op, r_a_dur;
    logic [TIME_BITS-1:0] r_a_pos;
    logic [X_W-1:0]       r_a_xp, r_a_xl;
    // stage B: seconds
    logic                 r_b_op, r_b_dur;
    logic [TS_W-1:0]      r_b_ts_p, r_b_ts_l, r_b_fl;
    // stage C: minutes
    logic                 r_c_dur, r_c_el;
    logic [TS_W-1:0]      r_c_ts_p, r_c_ts_l;
    logic [MT_W-1:0]      r_c_mt_p, r_c_mt_l;
    // stage D: hours
    logic                 r_d_dur, r_d_el;
    logic [5:0]           r_d_sec_p, r_d_sec_l;
    logic [MT_W-1:0]      r_d_mt_p, r_d_mt_l;
    logic [HR_W-1:0]      r_d_hr_p, r_d_hr_l;
    // stage E: fields
    logic                 r_e_dur, r_e_el;
    logic [5:0]           r_e_sec_p, r_e_sec_l, r_e_min_p, r_e_min_l;
    logic [6:0]           r_e_hr_p, r_e_hr_l;
    t_hour_w              r_e_hw;

    logic                 en, accept, len_change, need_push;
    logic [TIME_BITS-1:0] l_eff;
    logic [P1_W-1:0]      p_rp, p_rl, p_fl;
    logic [P2_W-1:0]      p_mp, p_ml;
    logic [P3_W-1:0]      p_hp, p_hl;
    logic [H100_W-1:0]    p_qp, p_ql;
    logic [3:0]           q_p, q_l;
    logic [6:0]           hr100_p, hr100_l;
    logic [5:0]           min_p, min_l;
    logic [5:0]           sec_p, sec_l;
    logic                 el_now;

    assign need_push = r_e_dur | r_e_el;
    assign en        = !(r_e_valid && need_push && i_full);
    assign accept    = i_in.valid && en;
    assign i_in.ready = en;

    assign len_change = (i_in.operation == OP_REPORT) &&
                        (!r_len_known || (r_stored_len != i_in.length_ms));
    // a forced update formats with the stored duration (zero until known)
    assign l_eff = (i_in.operation == OP_REPORT) ? i_in.length_ms : r_stored_len;

    assign p_rp = P1_W'(r_a_xp[X_W-1:3]) * P1_W'(M125_W'(R125));
    assign p_rl = P1_W'(r_a_xl[X_W-1:3]) * P1_W'(M125_W'(R125));
    assign p_fl = P1_W'(r_a_pos[TIME_BITS-1:3]) * P1_W'(M125_W'(R125));

    assign p_mp = P2_W'(r_b_ts_p[TS_W-1:2]) * P2_W'(M15S_W'(R15S));
    assign p_ml = P2_W'(r_b_ts_l[TS_W-1:2]) * P2_W'(M15S_W'(R15S));

    assign el_now = (r_b_op == OP_FORCED) || !r_pos_known || (r_b_fl != r_last_sec);

    assign p_hp = P3_W'(r_c_mt_p[MT_W-1:2]) * P3_W'(M15M_W'(R15M));
    assign p_hl = P3_W'(r_c_mt_l[MT_W-1:2]) * P3_W'(M15M_W'(R15M));
    assign sec_p = 6'(r_c_ts_p - TS_W'(r_c_mt_p) * TS_W'(60));
    assign sec_l = 6'(r_c_ts_l - TS_W'(r_c_mt_l) * TS_W'(60));

    assign min_p = 6'(r_d_mt_p - MT_W'(r_d_hr_p) * MT_W'(60));
    assign min_l = 6'(r_d_mt_l - MT_W'(r_d_hr_l) * MT_W'(60));
    assign p_qp  = H100_W'(r_d_hr_p) * H100_W'(41);
    assign p_ql  = H100_W'(r_d_hr_l) * H100_W'(41);
    assign q_p   = p_qp[H100_W-1:12];
    assign q_l   = p_ql[H100_W-1:12];
    assign hr100_p = 7'(r_d_hr_p - HR_W'(q_p) * HR_W'(100));
    assign hr100_l = 7'(r_d_hr_l - HR_W'(q_l) * HR_W'(100));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_len <= '0;
            r_len_known  <= 1'b0;
            r_last_sec   <= '0;
            r_pos_known  <= 1'b0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_e_valid    <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            if (accept && (i_in.operation == OP_REPORT)) begin
                r_stored_len <= i_in.length_ms;
                r_len_known  <= 1'b1;
            end
            if (r_b_valid) begin
                r_last_sec  <= r_b_fl;
                r_pos_known <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_op  <= i_in.operation;
            r_a_dur <= len_change;
            r_a_pos <= i_in.position_ms;
            r_a_xp  <= X_W'(i_in.position_ms) + X_W'(ROUND_MS);
            r_a_xl  <= X_W'(l_eff) + X_W'(ROUND_MS);

            r_b_op   <= r_a_op;
            r_b_dur  <= r_a_dur;
            r_b_ts_p <= p_rp[K125 +: TS_W];
            r_b_ts_l <= p_rl[K125 +: TS_W];
            r_b_fl   <= p_fl[K125 +: TS_W];

            r_c_dur  <= r_b_dur;
            r_c_el   <= el_now;
            r_c_ts_p <= r_b_ts_p;
            r_c_ts_l <= r_b_ts_l;
            r_c_mt_p <= p_mp[K15S +: MT_W];
            r_c_mt_l <= p_ml[K15S +: MT_W];

            r_d_dur   <= r_c_dur;
            r_d_el    <= r_c_el;
            r_d_sec_p <= sec_p;
            r_d_sec_l <= sec_l;
            r_d_mt_p  <= r_c_mt_p;
            r_d_mt_l  <= r_c_mt_l;
            r_d_hr_p  <= p_hp[K15M +: HR_W];
            r_d_hr_l  <= p_hl[K15M +: HR_W];

            r_e_dur   <= r_d_dur;
            r_e_el    <= r_d_el;
            r_e_sec_p <= r_d_sec_p;
            r_e_sec_l <= r_d_sec_l;
            r_e_min_p <= min_p;
            r_e_min_l <= min_l;
            r_e_hr_p  <= hr100_p;
            r_e_hr_l  <= hr100_l;
            // field layout follows the duration's hours
            if (r_d_hr_l == '0) begin
                r_e_hw <= HW_NONE;
            end else if (r_d_hr_l < HR_W'(10)) begin
                r_e_hw <= HW_ONE;
            end else begin
                r_e_hw <= HW_TWO;
            end
        end
    end

    always_comb begin
        o_entry.emit_dur = r_e_dur;
        o_entry.emit_el  = r_e_el;
        o_entry.hour_w   = r_e_hw;
        o_entry.min_two  = (r_e_min_l >= 6'd10);
        {o_entry.dur.h1, o_entry.dur.h0} = split10(r_e_hr_l);
        {o_entry.dur.m1, o_entry.dur.m0} = split10({1'b0, r_e_min_l});
        {o_entry.dur.s1, o_entry.dur.s0} = split10({1'b0, r_e_sec_l});
        {o_entry.el.h1, o_entry.el.h0}   = split10(r_e_hr_p);
        {o_entry.el.m1, o_entry.el.m0}   = split10({1'b0, r_e_min_p});
        {o_entry.el.s1, o_entry.el.s0}   = split10({1'b0, r_e_sec_p});
    end

    assign o_push = r_e_valid && need_push && !i_full;

endmodule

// ----- hdl/mtdf_queue.sv -----
module mtdf_queue import mtdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_fmt_entry i_data,
    output logic       o_full,
    input  logic       i_pop,
    output t_fmt_entry o_data,
    output logic       o_valid
);

    t_fmt_entry      r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hdl/mtdf_back.sv -----
module mtdf_back import mtdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fmt_entry i_entry,
    input  logic       i_valid,
    output logic       o_pop,
    mtdf_out_if.source o_out
);

    // character slots of the widest layout H1 H0 : M1 M0 : S1 S0
    localparam logic [2:0] SL_H1 = 3'd0;
    localparam logic [2:0] SL_H0 = 3'd1;
    localparam logic [2:0] SL_C1 = 3'd2;
    localparam logic [2:0] SL_M1 = 3'd3;
    localparam logic [2:0] SL_M0 = 3'd4;
    localparam logic [2:0] SL_C2 = 3'd5;
    localparam logic [2:0] SL_S1 = 3'd6;
    localparam logic [2:0] SL_S0 = 3'd7;

    logic       r_busy;
    logic       r_str;
    logic [2:0] r_slot;

    logic       r_o_valid;
    logic       r_kind;
    logic [7:0] r_char;
    logic       r_send;
    logic       r_iend;

    logic       load, fire, last_slot, item_last;
    logic       cur_str;
    logic [2:0] start, cur_slot;
    t_digits    dg;
    logic [7:0] ch;

    always_comb begin
        unique case (i_entry.hour_w)
            HW_TWO:  start = SL_H1;
            HW_ONE:  start = SL_H0;
            HW_NONE: start = i_entry.min_two ? SL_M1 : SL_M0;
            default: start = SL_M0;
        endcase
    end

    assign cur_str  = r_busy ? r_str  : (i_entry.emit_dur ? EV_DURATION : EV_ELAPSED);
    assign cur_slot = r_busy ? r_slot : start;
    assign dg       = (cur_str == EV_ELAPSED) ? i_entry.el : i_entry.dur;

    always_comb begin
        unique case (cur_slot)
            SL_H1: ch = CHAR_ZERO + {4'd0, dg.h1};
            SL_H0: ch = CHAR_ZERO + {4'd0, dg.h0};
            SL_C1: ch = CHAR_COLON;
            SL_M1: ch = CHAR_ZERO + {4'd0, dg.m1};
            SL_M0: ch = CHAR_ZERO + {4'd0, dg.m0};
            SL_C2: ch = CHAR_COLON;
            SL_S1: ch = CHAR_ZERO + {4'd0, dg.s1};
            SL_S0: ch = CHAR_ZERO + {4'd0, dg.s0};
        endcase
    end

    assign load      = !r_o_valid || o_out.ready;
    assign fire      = i_valid && load;
    assign last_slot = (cur_slot == SL_S0);
    assign item_last = last_slot && ((cur_str == EV_ELAPSED) || !i_entry.emit_el);
    assign o_pop     = fire && item_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_busy    <= 1'b0;
        end else begin
            if (load) begin
                r_o_valid <= fire;
            end
            if (fire) begin
                if (item_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            // duration string done: elapsed string reuses the same layout
            if (last_slot) begin
                r_str  <= EV_ELAPSED;
                r_slot <= start;
            end else begin
                r_str  <= cur_str;
                r_slot <= cur_slot + 3'd1;
            end
            r_kind <= cur_str;
            r_char <= ch;
            r_send <= last_slot;
            r_iend <= item_last;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.event_kind = r_kind;
    assign o_out.character  = r_char;
    assign o_out.string_end = r_send;
    assign o_out.item_end   = r_iend;

endmodule
